[rtl/core/lpr_pkg.sv]
// Shared types and constants for the LRU page replacement tracker.
package lpr_pkg;

  localparam int PAGE_NUMBER_W = 16;
  localparam int TOTAL_W       = 32;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index is paddr bit 2 (one word per register)
  localparam logic REG_FRAME_CAPACITY = 1'b0;

  typedef struct packed {
    logic [PAGE_NUMBER_W-1:0] page_number;
    logic                     last_request;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] fault_total;
    logic               totals_final;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lpr_state_e;

  typedef struct packed {
    logic load;    // capture input word
    logic lookup;  // tag compare, pick target frame
    logic commit;  // update frames and counters, load output register
    logic take;    // output word leaves this cycle
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_sts_t;

endpackage

[rtl/core/lpr_ctrl.sv]
// Request sequencer: idle, lookup and update steps for one word at a time.
module lpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  input  lpr_pkg::dp_sts_t   sts_i,
  output lpr_pkg::ctrl_cmd_t cmd_o
);

  lpr_pkg::lpr_state_e state_q, state_d;
  logic                can_commit;

  assign can_commit = !sts_i.out_full || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lpr_pkg::ST_MATCH;
      end
      lpr_pkg::ST_MATCH: begin
        state_d = lpr_pkg::ST_UPDATE;
      end
      lpr_pkg::ST_UPDATE: begin
        if (can_commit) state_d = lpr_pkg::ST_IDLE;
      end
      default: begin
        state_d = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    cmd_o.take    = sts_i.out_full && !out_stall_i;
    case (state_q)
      lpr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      lpr_pkg::ST_MATCH: begin
        cmd_o.lookup = 1'b1;
      end
      lpr_pkg::ST_UPDATE: begin
        cmd_o.commit = can_commit;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/lpr_datapath.sv]
// Frame tags, recency ranks, hit/fault counters and the output register.
module lpr_datapath #(
  parameter int FRAMES     = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpr_pkg::ctrl_cmd_t          cmd_i,
  output lpr_pkg::dp_sts_t            sts_o,
  input  lpr_pkg::in_word_t           in_data_i,
  input  logic [lpr_pkg::CAP_W-1:0]   cap_i,
  output lpr_pkg::out_word_t          out_data_o
);

  localparam int RW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int UW    = $clog2(FRAMES + 1);
  localparam int CmpW  = ((UW > lpr_pkg::CAP_W) ? UW : lpr_pkg::CAP_W) + 1;
  localparam int ExtW  = (COUNT_BITS > lpr_pkg::TOTAL_W) ? COUNT_BITS : lpr_pkg::TOTAL_W;

  // captured request
  logic [PAGE_BITS-1:0]  page_q;
  logic                  last_q;

  // frame state
  logic [PAGE_BITS-1:0]  tag_q  [FRAMES];
  logic [RW-1:0]         rank_q [FRAMES];
  logic [FRAMES-1:0]     valid_q;
  logic [UW-1:0]         used_q;
  logic [COUNT_BITS-1:0] hit_cnt_q, flt_cnt_q;

  // lookup result
  logic                  hit_q, ins_q;
  logic [FRAMES-1:0]     sel_q;

  // output register
  lpr_pkg::out_word_t    out_q;
  logic                  out_valid_q;

  // ---------------- lookup ----------------
  logic [FRAMES-1:0]     match, match_first;
  logic [FRAMES-1:0]     free, free_first;
  logic [FRAMES-1:0]     victim, victim_first;
  logic [RW-1:0]         lru_rank;
  logic [CmpW-1:0]       cap_ext, used_ext, eff_cap;
  logic                  hit_c, full_c;

  assign cap_ext  = CmpW'(cap_i);
  assign used_ext = CmpW'(used_q);
  assign lru_rank = RW'(used_q - UW'(1));

  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(FRAMES)) begin
      eff_cap = CmpW'(FRAMES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = valid_q[i] && (tag_q[i] == page_q);
      victim[i] = valid_q[i] && (rank_q[i] == lru_rank);
    end
  end

  assign free         = ~valid_q;
  // isolate lowest set bit
  assign match_first  = match  & (~match  + FRAMES'(1));
  assign free_first   = free   & (~free   + FRAMES'(1));
  assign victim_first = victim & (~victim + FRAMES'(1));
  assign hit_c        = |match;
  assign full_c       = used_ext >= eff_cap;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= PAGE_BITS'(in_data_i.page_number);
      last_q <= in_data_i.last_request;
    end
    if (cmd_i.lookup) begin
      hit_q <= hit_c;
      ins_q <= !hit_c && !full_c;
      sel_q <= hit_c ? match_first : (full_c ? victim_first : free_first);
    end
  end

  // ---------------- update ----------------
  logic [RW-1:0]         old_rank;
  logic [COUNT_BITS-1:0] hit_cnt_n, flt_cnt_n;
  logic [ExtW-1:0]       hit_ext, flt_ext;

  always_comb begin
    old_rank = '0;
    for (int i = 0; i < FRAMES; i++) begin
      old_rank = old_rank | (sel_q[i] ? rank_q[i] : '0);
    end
  end

  assign hit_cnt_n = (hit_q && (hit_cnt_q != '1)) ? hit_cnt_q + COUNT_BITS'(1) : hit_cnt_q;
  assign flt_cnt_n = (!hit_q && (flt_cnt_q != '1)) ? flt_cnt_q + COUNT_BITS'(1) : flt_cnt_q;
  assign hit_ext   = ExtW'(hit_cnt_n);
  assign flt_ext   = ExtW'(flt_cnt_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      used_q    <= '0;
      hit_cnt_q <= '0;
      flt_cnt_q <= '0;
      for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
    end else if (cmd_i.commit) begin
      hit_cnt_q <= hit_cnt_n;
      flt_cnt_q <= flt_cnt_n;
      if (ins_q) used_q <= used_q + UW'(1);
      for (int i = 0; i < FRAMES; i++) begin
        if (sel_q[i]) begin
          rank_q[i] <= '0;
          if (ins_q) valid_q[i] <= 1'b1;
        end else if (valid_q[i] && (ins_q || (rank_q[i] < old_rank))) begin
          rank_q[i] <= rank_q[i] + RW'(1);
        end
      end
    end
  end

  // tags hold no reset; only read behind a valid bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit_q) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (sel_q[i]) tag_q[i] <= page_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.hit          <= hit_q;
      out_q.hit_total    <= hit_ext[lpr_pkg::TOTAL_W-1:0];
      out_q.fault_total  <= flt_ext[lpr_pkg::TOTAL_W-1:0];
      out_q.totals_final <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (cmd_i.take) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign out_data_o     = out_q;

endmodule

[rtl/core/lru_page_replacement_tracker_top.sv]
// Top level of the LRU page replacement tracker: sequencer, datapath, register port.
//
//   channel  direction  word        handshake
//   -------  ---------  ----------  -------------------------------
//   in       input      in_word_t   in_valid_i / in_stall_o
//   out      output     out_word_t  out_valid_o / out_stall_i
//   cfg      input      APB         psel, penable, pwrite, pready
//
// Each request goes through capture, tag compare over all frames,
// then the recency-rank update and counter step that load the output register.
// The output register lets the next request come in while a result waits;
// a stalled result only holds the update step until the register drains.
// Reset clears valid bits, ranks, frame count, totals and sets capacity to 16.
// Frame tags are not reset; they are only compared behind their valid bits.
module lru_page_replacement_tracker_top #(
  parameter int FRAMES     = 16,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lpr_pkg::in_word_t                in_data_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lpr_pkg::out_word_t               out_data_o,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lpr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lpr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lpr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  lpr_pkg::ctrl_cmd_t          cmd;
  lpr_pkg::dp_sts_t            sts;
  logic [lpr_pkg::CAP_W-1:0]   cap_q;
  logic                        reg_hit;

  // ---- register port: single capacity register at word 0 ----
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == lpr_pkg::REG_FRAME_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lpr_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cap_q <= pwdata[lpr_pkg::CAP_W-1:0];
    end
  end

  assign prdata = reg_hit ? lpr_pkg::APB_DATA_W'(cap_q) : '0;

  // ---- sequencer ----
  lpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ---- frame state and totals ----
  lpr_datapath #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .cap_i      (cap_q),
    .out_data_o (out_data_o)
  );

  assign out_valid_o = sts.out_full;

endmodule

[rtl/core/lpr_checker.sv]
// Port-level checks for the LRU page replacement tracker, bound to the top level.
module lpr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input lpr_pkg::out_word_t out_data_i
);

  // a taken word is followed by busy lookup and update steps
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |=> in_stall_i ##1 in_stall_i)
    else $error("input taken again before lookup and update finished");

  // a fresh result only appears at the end of an update step
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result appeared without a request in work");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> $stable(out_data_i))
    else $error("output word changed while stalled");

endmodule

bind lru_page_replacement_tracker_top lpr_checker u_lpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
